FILE: hw/rtl/swmcd_pkg.sv
// Package for the switch matrix change detector.
// Holds matrix sizes, register codes and the input and event transfer types.
// No dependencies.
package swmcd_pkg;

  // Matrix geometry
  localparam int Columns = 8;
  localparam int Rows    = 8;
  localparam int RowSpan = 8;

  localparam int ColAddrW = $clog2(Columns);

  // Configuration port
  localparam int CfgAddrW = 4;
  localparam int CfgDataW = 64;

  // Register index codes (byte address is 8 times the index)
  localparam logic RegWatchMask = 1'b0;

  // Rows above Rows are dropped before compare and store
  localparam logic [RowSpan-1:0] RowMask = RowSpan'((1 << Rows) - 1);

  typedef struct packed {
    logic [2:0] column;
    logic [7:0] row_bits;
  } in_item_t;

  typedef struct packed {
    logic [2:0] event_column;
    logic [2:0] event_row;
    logic       switch_active;
    logic       last;
  } out_item_t;

endpackage

FILE: hw/rtl/switch_matrix_change_detector.sv
// Switch matrix change detector: per-column compare against the stored scan.
// Timing: an accepted column is compared in the cycle after its input transfer;
// its events are then registered in the event stage. Throughput: one event per cycle
// while out_stall_i is low; a column with events waits while the event stage is busy.
// Reset: watch mask cleared, stored scan reads as all zeros (per-column valid
// bits), no clearing pass. Depends on swmcd_pkg and swmcd_ram.
module switch_matrix_change_detector
  import swmcd_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  // input column samples
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  in_item_t            in_data_i,
  // switch events
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output out_item_t           out_data_o,
  // configuration
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [CfgAddrW-1:0] paddr,
  input  logic [CfgDataW-1:0] pwdata,
  output logic [CfgDataW-1:0] prdata,
  output logic                pready
);

  // ---------------------------------------------------------------------------
  // Configuration register
  // ---------------------------------------------------------------------------
  logic [63:0] watch_mask_q, watch_mask_d;
  logic        cfg_write;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && (paddr[3] == RegWatchMask);
  assign prdata    = (paddr[3] == RegWatchMask) ? watch_mask_q : '0;

  always_comb begin
    watch_mask_d = watch_mask_q;
    if (cfg_write) begin
      watch_mask_d = pwdata;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      watch_mask_q <= '0;
    end else begin
      watch_mask_q <= watch_mask_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Snapshot memory and per-column valid bits
  // ---------------------------------------------------------------------------
  logic                in_xfer;
  logic                ram_we;
  logic [ColAddrW-1:0] ram_waddr;
  logic [RowSpan-1:0]  ram_wdata;
  logic [RowSpan-1:0]  ram_rdata;
  logic [Columns-1:0]  col_vld_q, col_vld_d;

  assign in_xfer = in_valid_i && !in_stall_o;

  swmcd_ram #(
    .Width(RowSpan),
    .Depth(Columns)
  ) u_snap_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (in_xfer),
    .raddr_i(in_data_i.column[ColAddrW-1:0]),
    .rdata_o(ram_rdata)
  );

  // ---------------------------------------------------------------------------
  // Compare stage: previous scan, with bypass of the latest write
  // ---------------------------------------------------------------------------
  logic                s1_vld_q, s1_vld_d;
  logic [2:0]          s1_col_q;
  logic [RowSpan-1:0]  s1_now_q;
  logic                fwd_vld_q, fwd_vld_d;
  logic [ColAddrW-1:0] fwd_col_q;
  logic [RowSpan-1:0]  fwd_data_q;
  logic                s1_col_ok;
  logic [RowSpan-1:0]  s1_prev;
  logic [RowSpan-1:0]  s1_watch;
  logic [RowSpan-1:0]  s1_changed;
  logic                s1_move;
  logic                s2_take;

  assign s1_col_ok = (32'(s1_col_q) < Columns);
  assign s1_watch  = watch_mask_q[s1_col_q*RowSpan +: RowSpan];

  always_comb begin
    if (fwd_vld_q && (fwd_col_q == s1_col_q[ColAddrW-1:0])) begin
      s1_prev = fwd_data_q;
    end else if (col_vld_q[s1_col_q[ColAddrW-1:0]]) begin
      s1_prev = ram_rdata;
    end else begin
      s1_prev = '0;
    end
  end

  assign s1_changed = s1_col_ok ? ((s1_now_q ^ s1_prev) & s1_watch & RowMask) : '0;

  // The item leaves unless it has events and the event stage is still busy
  assign s1_move    = s1_vld_q && ((s1_changed == '0) || s2_take);
  assign in_stall_o = s1_vld_q && !s1_move;

  assign ram_we    = s1_move && s1_col_ok;
  assign ram_waddr = s1_col_q[ColAddrW-1:0];
  assign ram_wdata = s1_now_q;

  always_comb begin
    s1_vld_d  = s1_vld_q;
    fwd_vld_d = fwd_vld_q;
    col_vld_d = col_vld_q;
    if (s1_move) begin
      s1_vld_d = 1'b0;
    end
    if (in_xfer) begin
      s1_vld_d = 1'b1;
    end
    if (ram_we) begin
      fwd_vld_d            = 1'b1;
      col_vld_d[ram_waddr] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      fwd_vld_q <= 1'b0;
      col_vld_q <= '0;
    end else begin
      s1_vld_q  <= s1_vld_d;
      fwd_vld_q <= fwd_vld_d;
      col_vld_q <= col_vld_d;
    end
  end

  // Payload of the compare stage and the bypass register
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s1_col_q <= in_data_i.column;
      s1_now_q <= in_data_i.row_bits & RowMask;
    end
    if (ram_we) begin
      fwd_col_q  <= ram_waddr;
      fwd_data_q <= ram_wdata;
    end
  end

  // ---------------------------------------------------------------------------
  // Event stage: one event per transfer, lowest pending row first
  // ---------------------------------------------------------------------------
  logic               s2_vld_q, s2_vld_d;
  logic [RowSpan-1:0] s2_pend_q, s2_pend_d;
  logic [2:0]         s2_col_q;
  logic [RowSpan-1:0] s2_now_q;
  logic [2:0]         s2_row;
  logic               s2_last;
  logic               out_xfer;
  logic               s2_load;

  // Priority encoder for the lowest pending row
  always_comb begin
    s2_row = '0;
    for (int r = RowSpan - 1; r >= 0; r--) begin
      if (s2_pend_q[r]) begin
        s2_row = 3'(r);
      end
    end
  end

  assign s2_last  = ((s2_pend_q & (s2_pend_q - 1'b1)) == '0);
  assign out_xfer = s2_vld_q && !out_stall_i;
  assign s2_take  = !s2_vld_q || (out_xfer && s2_last);
  assign s2_load  = s1_move && (s1_changed != '0);

  assign out_valid_o                = s2_vld_q;
  assign out_data_o.event_column    = s2_col_q;
  assign out_data_o.event_row       = s2_row;
  assign out_data_o.switch_active   = ~s2_now_q[s2_row];
  assign out_data_o.last            = s2_last;

  always_comb begin
    s2_vld_d  = s2_vld_q;
    s2_pend_d = s2_pend_q;
    if (out_xfer) begin
      s2_pend_d = s2_pend_q & (s2_pend_q - 1'b1);
      if (s2_last) begin
        s2_vld_d = 1'b0;
      end
    end
    if (s2_load) begin
      s2_vld_d  = 1'b1;
      s2_pend_d = s1_changed;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_vld_q  <= 1'b0;
      s2_pend_q <= '0;
    end else begin
      s2_vld_q  <= s2_vld_d;
      s2_pend_q <= s2_pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_load) begin
      s2_col_q <= s1_col_q;
      s2_now_q <= s1_now_q;
    end
  end

endmodule

FILE: hw/rtl/swmcd_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// Read returns the old contents when read and write hit the same address.
// No dependencies.
module swmcd_ram #(
  parameter int Width = 8,
  parameter int Depth = 8
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port, holds when not enabled
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: sim/switch_matrix_change_detector_tb.sv
// Testbench for switch_matrix_change_detector: column samples in, switch events out.
// A scoreboard class predicts the events; tasks drive the stream and APB ports.
// Depends on swmcd_pkg and the block's RTL.
module switch_matrix_change_detector_tb;
  import swmcd_pkg::*;

  localparam int RegUnused = 1;
  localparam logic [CfgAddrW-1:0] MaskAddr   = CfgAddrW'(8 * int'(RegWatchMask));
  localparam logic [CfgAddrW-1:0] UnusedAddr = CfgAddrW'(8 * RegUnused);
  localparam int HoldCycles  = 150;
  localparam int SettleCycles = 12;
  localparam int PhaseItems  = 23;

  // Predicts switch events from column samples and checks them in order
  class switch_event_book;
    bit [7:0]       last_scan [Columns];
    bit [63:0]      watch;
    out_item_t      pending_events [$];
    int             errors;

    function void set_watch(bit [63:0] value);
      watch = value;
    endfunction

    // Work out the events caused by one accepted column transfer
    function void note_column(in_item_t item);
      bit [7:0]  now;
      bit [7:0]  diff;
      out_item_t ev;
      now = item.row_bits & RowMask;
      if (int'(item.column) < Columns) begin
        diff = (now ^ last_scan[item.column]) & RowMask &
               watch[int'(item.column) * RowSpan +: 8];
        for (int r = 0; r < Rows; r++) begin
          if (diff[r]) begin
            ev.event_column  = item.column;
            ev.event_row     = 3'(r);
            ev.switch_active = ~now[r];
            ev.last          = ((diff >> (r + 1)) == 8'h00);
            pending_events.push_back(ev);
          end
        end
        last_scan[item.column] = now;
      end
    endfunction

    // Compare one accepted event with the oldest prediction
    function void check_event(out_item_t got);
      out_item_t want;
      if (pending_events.size() == 0) begin
        errors++;
        $display({"%0t: unexpected event: expected none, ",
                  "actual col %0d row %0d active %0b last %0b"},
                 $time, got.event_column, got.event_row, got.switch_active, got.last);
        return;
      end
      want = pending_events.pop_front();
      if (got.event_column !== want.event_column || got.event_row !== want.event_row ||
          got.switch_active !== want.switch_active || got.last !== want.last) begin
        errors++;
        $display({"%0t: event mismatch: expected col %0d row %0d active %0b last %0b, ",
                  "actual col %0d row %0d active %0b last %0b"},
                 $time, want.event_column, want.event_row, want.switch_active, want.last,
                 got.event_column, got.event_row, got.switch_active, got.last);
      end
    endfunction
  endclass

  logic                clk_i;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_stall_o;
  in_item_t            in_data_i;
  logic                out_valid_o;
  logic                out_stall_i;
  out_item_t           out_data_o;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [CfgAddrW-1:0] paddr;
  logic [CfgDataW-1:0] pwdata;
  logic [CfgDataW-1:0] prdata;
  logic                pready;

  switch_event_book sb = new();
  bit calm;
  bit pressure_req;

  switch_matrix_change_detector u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Run limit
  initial begin
    #2000000;
    $display("DONE: errors detected");
    $finish;
  end

  // Receiver: random stall bursts, one long hold-off on request, none when calm
  initial begin
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (pressure_req) begin
        pressure_req = 1'b0;
        out_stall_i <= 1'b1;
        repeat (HoldCycles - 1) @(negedge clk_i);
      end else if (!calm && $urandom_range(0, 4) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(0, 9)) @(negedge clk_i);
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // Event monitor
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) sb.check_event(out_data_o);
  end

  // Offer one column sample until it transfers, then maybe leave a gap
  task automatic send_column(input logic [2:0] col, input logic [7:0] bits);
    in_item_t item;
    item.column   = col;
    item.row_bits = bits;
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    in_data_i  <= item;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_column(item);
    if (!calm && $urandom_range(0, 3) == 0) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      repeat ($urandom_range(0, 9)) @(negedge clk_i);
    end
  endtask

  // APB write: setup cycle, then access cycle until pready
  task automatic apb_write(input logic [CfgAddrW-1:0] addr, input logic [63:0] value);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (addr == MaskAddr) sb.set_watch(value);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // APB read of the watch mask, checked against the predicted value
  task automatic apb_check_mask();
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= MaskAddr;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== sb.watch) begin
      sb.errors++;
      $display("%0t: watch mask readback: expected %h, actual %h", $time, sb.watch, prdata);
    end
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Drop valid and wait for the block to drain before touching registers
  task automatic drain();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (sb.pending_events.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // Random samples: mostly small edits of the stored scan, some fresh values
  task automatic run_random(input int n);
    logic [2:0] col;
    logic [7:0] bits;
    int         pick;
    for (int i = 0; i < n; i++) begin
      col  = 3'($urandom_range(0, Columns - 1));
      bits = sb.last_scan[col];
      pick = $urandom_range(0, 9);
      if (pick < 4) bits = 8'($urandom);
      else if (pick < 7) bits[$urandom_range(0, 7)] ^= 1'b1;
      else if (pick < 9) bits ^= 8'($urandom) & 8'($urandom);
      send_column(col, bits);
    end
  endtask

  // Main sequence
  initial begin
    rst_ni     = 1'b0;
    in_valid_i = 1'b0;
    in_data_i  = '0;
    psel       = 1'b0;
    penable    = 1'b0;
    pwrite     = 1'b0;
    paddr      = '0;
    pwdata     = '0;
    calm       = 1'b0;
    pressure_req = 1'b0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Unused register index is ignored; mask resets to zero
    apb_write(UnusedAddr, '1);
    apb_check_mask();
    apb_write(MaskAddr, '1);
    apb_check_mask();

    // Directed: full flips from reset scan, repeats, one sample per remaining column
    send_column(3'd0, 8'hFF);
    send_column(3'd0, 8'h00);
    send_column(3'd0, 8'h00);
    send_column(3'd7, 8'hA5);
    send_column(3'd7, 8'h5A);
    send_column(3'd1, 8'h01);
    send_column(3'd2, 8'h80);
    send_column(3'd3, 8'hFF);
    send_column(3'd4, 8'h7F);
    send_column(3'd5, 8'hFE);
    send_column(3'd6, 8'hAA);
    drain();

    // Directed: nothing watched, scan still updates
    apb_write(MaskAddr, '0);
    apb_check_mask();
    send_column(3'd0, 8'hFF);
    send_column(3'd1, 8'hFE);
    send_column(3'd7, 8'h00);
    drain();

    // Directed: only the two corner switches watched
    apb_write(MaskAddr, 64'h8000_0000_0000_0001);
    send_column(3'd0, 8'h00);
    send_column(3'd7, 8'hFF);
    send_column(3'd3, 8'h00);
    drain();

    // Random phases over several masks
    apb_write(MaskAddr, {$urandom, $urandom});
    apb_check_mask();
    run_random(PhaseItems);
    drain();

    apb_write(MaskAddr, '1);
    pressure_req = 1'b1;
    run_random(PhaseItems);
    drain();

    apb_write(MaskAddr, 64'h5555_5555_5555_5555);
    run_random(PhaseItems);
    drain();

    apb_write(MaskAddr, {$urandom, $urandom} | 64'hFF00_0000_0000_00FF);
    apb_check_mask();
    run_random(PhaseItems);
    drain();

    // Final stretch with no idling on either side
    calm = 1'b1;
    apb_write(MaskAddr, '1);
    run_random(PhaseItems);
    drain();

    if (sb.errors == 0 && sb.pending_events.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
